FILE: hdl/bgum_pkg.sv
// Package for the boost group utilization margin block.
// Holds request codes, sequencer states, command/status structs and constants.
// No dependencies.
`default_nettype none

package bgum_pkg;

  // Request codes of the input word
  typedef enum logic [2:0] {
    REQ_ENQUEUE   = 3'd0,
    REQ_DEQUEUE   = 3'd1,
    REQ_MOVE      = 3'd2,
    REQ_QUERY     = 3'd3,
    REQ_SET_BOOST = 3'd4
  } req_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CPU_CAPACITY = 1'd1;

  localparam logic [31:0] HOLD_RESET = 32'd50000000;
  localparam logic [10:0] CAP_RESET  = 11'd1024;
  localparam logic signed [7:0] BOOST_LIMIT = 8'sd100;

  // Divide by 100: floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for x < 2^20
  localparam logic [19:0] RECIP_100   = 20'd671089;
  localparam int unsigned RECIP_SHIFT = 26;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MOVE_DST,
    ST_SCAN,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic sel_dst;
    logic scan;
    logic scan_end;
    logic cnt_inc;
    logic cnt_dec;
    logic stamp_rt;
    logic stamp;
    logic set_boost;
    logic mul;
    logic div;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic in_valid;
    logic grp_cnt_zero;
    logic same_grp;
    logic query_expired;
    logic scan_last;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

FILE: hdl/bgum_if.sv
// Channel interfaces of the boost group utilization margin block.
// Request channel and response channel, each with valid/ready. No dependencies.
`default_nettype none

interface bgum_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [2:0]  group;
  logic [7:0]  dst_group;
  logic        is_rt;
  logic [63:0] now;
  logic [11:0] util;
  logic signed [7:0] boost_value;

  modport source (output valid, req_type, group, dst_group, is_rt, now, util, boost_value,
                  input ready);
  modport sink   (input valid, req_type, group, dst_group, is_rt, now, util, boost_value,
                  output ready);
endinterface

interface bgum_rsp_if;
  logic        valid;
  logic        ready;
  logic [11:0] boosted_util;
  logic signed [12:0] margin;
  logic signed [7:0]  peak_boost;
  logic        any_active;

  modport source (output valid, boosted_util, margin, peak_boost, any_active, input ready);
  modport sink   (input valid, boosted_util, margin, peak_boost, any_active, output ready);
endinterface

`default_nettype wire

FILE: hdl/bgum_ctrl.sv
// Sequencer of the boost group utilization margin block.
// Depends on bgum_pkg for states, command and status structs.
`default_nettype none

module bgum_ctrl import bgum_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  status_t stat,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (stat.in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        case (stat.req)
          REQ_ENQUEUE: state_next = stat.grp_cnt_zero ? ST_SCAN : ST_DONE;
          REQ_MOVE:    state_next = stat.same_grp ? ST_DONE : ST_MOVE_DST;
          REQ_QUERY:   state_next = stat.query_expired ? ST_SCAN : ST_MUL;
          default:     state_next = ST_DONE;
        endcase
      end
      ST_MOVE_DST: state_next = ST_DONE;
      ST_SCAN: begin
        if (stat.scan_last) state_next = (stat.req == REQ_QUERY) ? ST_MUL : ST_DONE;
      end
      ST_MUL:  state_next = ST_DIV;
      ST_DIV:  state_next = ST_DONE;
      ST_DONE: begin
        if (!stat.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: cmd.in_ready = 1'b1;
      ST_EXEC: begin
        case (stat.req)
          REQ_ENQUEUE: begin
            cmd.cnt_inc  = 1'b1;
            cmd.stamp_rt = 1'b1;
          end
          REQ_DEQUEUE:   cmd.cnt_dec = 1'b1;
          REQ_MOVE:      cmd.cnt_dec = !stat.same_grp;
          REQ_SET_BOOST: cmd.set_boost = 1'b1;
          default: ;
        endcase
      end
      ST_MOVE_DST: begin
        cmd.sel_dst = 1'b1;
        cmd.cnt_inc = 1'b1;
        cmd.stamp   = 1'b1;
      end
      ST_SCAN: begin
        cmd.scan     = 1'b1;
        cmd.scan_end = stat.scan_last;
      end
      ST_MUL:  cmd.mul = 1'b1;
      ST_DIV:  cmd.div = 1'b1;
      ST_DONE: cmd.out_load = !stat.out_busy;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/bgum_dp.sv
// Datapath of the boost group utilization margin block: group tables,
// rescan accumulator, margin arithmetic, config and output registers.
// Depends on bgum_pkg and the bgum_req_if / bgum_rsp_if interfaces.
`default_nettype none

module bgum_dp import bgum_pkg::*; #(
  parameter int NUM_GROUPS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  bgum_req_if.sink              req,
  bgum_rsp_if.source            rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  cmd_t                  cmd,
  output status_t               stat
);

  localparam int GW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam logic [GW-1:0] LAST_GRP = GW'(NUM_GROUPS - 1);

  // Captured word
  req_t              req_q;
  logic [GW-1:0]     grp_q, dst_q;
  logic              is_rt_q;
  logic [63:0]       now_q;
  logic [11:0]       util_q;
  logic signed [7:0] bv_q;

  logic [31:0] hold_timeout;
  logic [10:0] cpu_capacity;

  logic [15:0]       cnt  [NUM_GROUPS];
  logic [63:0]       hold [NUM_GROUPS];
  logic signed [7:0] boost[NUM_GROUPS];

  logic signed [7:0] max_boost;
  logic              max_valid;
  logic [63:0]       max_time;

  logic [GW-1:0]     scan_idx;
  logic              found;
  logic signed [7:0] best;
  logic [63:0]       best_ts;

  logic [18:0] prod;
  logic        neg, has_margin;
  logic [11:0] quot;

  logic              out_valid;
  logic [11:0]       out_util;
  logic signed [12:0] out_margin;
  logic signed [7:0] out_boost;
  logic              out_active;

  logic              accept;
  logic [GW-1:0]     grp_c, dst_c, addr;
  logic [15:0]       rd_cnt;
  logic [63:0]       rd_hold;
  logic signed [7:0] rd_boost;
  logic [63:0]       elapsed;
  logic              active, take, found_n;
  logic signed [7:0] best_n, bv_sat;
  logic [63:0]       ts_n;
  logic [11:0]       mag;
  logic [6:0]        abs_boost;
  logic [38:0]       prod_k;
  logic signed [12:0] margin_v;
  logic signed [13:0] sum_v;
  logic [11:0]       sat_v;

  assign accept = req.valid && req.ready;
  // Hold off words while in reset
  assign req.ready = cmd.in_ready && !rst;

  assign grp_c = ({5'd0, req.group} >= 8'(NUM_GROUPS)) ? LAST_GRP : GW'(req.group);
  assign dst_c = (req.dst_group >= 8'(NUM_GROUPS)) ? LAST_GRP : GW'(req.dst_group);

  // One table address per cycle
  assign addr     = cmd.scan ? scan_idx : (cmd.sel_dst ? dst_q : grp_q);
  assign rd_cnt   = cnt[addr];
  assign rd_hold  = hold[addr];
  assign rd_boost = boost[addr];

  assign elapsed = now_q - rd_hold;
  assign active  = (rd_cnt != 16'd0) || !(elapsed > {32'd0, hold_timeout});
  assign take    = active && (!found || (rd_boost >= best));
  assign found_n = found || active;
  assign best_n  = take ? rd_boost : best;
  assign ts_n    = take ? rd_hold : best_ts;

  assign bv_sat = (bv_q > BOOST_LIMIT) ? BOOST_LIMIT :
                  (bv_q < -BOOST_LIMIT) ? -BOOST_LIMIT : bv_q;

  assign mag       = (max_boost > 8'sd0) ? ({1'b0, cpu_capacity} - util_q) : util_q;
  assign abs_boost = (max_boost < 8'sd0) ? 7'(-max_boost) : 7'(max_boost);
  assign prod_k    = 39'(prod) * 39'(RECIP_100);

  assign margin_v = !has_margin ? 13'sd0 :
                    neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  assign sum_v    = $signed({2'b00, util_q}) + {margin_v[12], margin_v};
  assign sat_v    = (sum_v < 14'sd0) ? 12'd0 :
                    (sum_v > 14'sd4095) ? 12'd4095 : sum_v[11:0];

  always_comb begin
    stat.req           = req_q;
    stat.in_valid      = req.valid;
    stat.grp_cnt_zero  = (rd_cnt == 16'd0);
    stat.same_grp      = (grp_q == dst_q);
    stat.query_expired = (now_q - max_time) > {32'd0, hold_timeout};
    stat.scan_last     = (scan_idx == LAST_GRP);
    stat.out_busy      = out_valid && !rsp.ready;
  end

  // Control and table state
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_timeout <= HOLD_RESET;
      cpu_capacity <= CAP_RESET;
      for (int g = 0; g < NUM_GROUPS; g++) begin
        cnt[g]   <= '0;
        hold[g]  <= '0;
        boost[g] <= '0;
      end
      max_boost <= '0;
      max_valid <= 1'b0;
      max_time  <= '0;
      scan_idx  <= '0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_HOLD_TIMEOUT: hold_timeout <= cfg_data;
          CFG_CPU_CAPACITY: cpu_capacity <= cfg_data[10:0];
          default: ;
        endcase
      end
      if (accept) begin
        scan_idx <= '0;
        found    <= 1'b0;
      end
      if (cmd.cnt_inc && (rd_cnt != 16'hFFFF)) cnt[addr] <= rd_cnt + 16'd1;
      if (cmd.cnt_dec && (rd_cnt != 16'd0))    cnt[addr] <= rd_cnt - 16'd1;
      if ((cmd.stamp_rt && is_rt_q) || cmd.stamp) hold[addr] <= now_q;
      // Move pushes the remembered stamp back so the next query rescans
      if (cmd.stamp) max_time <= now_q - {32'd0, hold_timeout};
      if (cmd.set_boost) boost[addr] <= bv_sat;
      if (cmd.scan) begin
        found    <= found_n;
        scan_idx <= scan_idx + GW'(1);
      end
      if (cmd.scan_end) begin
        max_valid <= found_n;
        max_boost <= found_n ? best_n : 8'sd0;
        if (found_n) max_time <= ts_n;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q   <= req_t'(req.req_type);
      grp_q   <= grp_c;
      dst_q   <= dst_c;
      is_rt_q <= req.is_rt;
      now_q   <= req.now;
      util_q  <= req.util;
      bv_q    <= req.boost_value;
    end
    if (cmd.scan) begin
      best    <= best_n;
      best_ts <= ts_n;
    end
    if (cmd.mul) begin
      prod       <= 19'(mag) * 19'(abs_boost);
      neg        <= (max_boost < 8'sd0);
      has_margin <= max_valid && (max_boost != 8'sd0) && (util_q <= {1'b0, cpu_capacity});
    end
    if (cmd.div) quot <= prod_k[RECIP_SHIFT +: 12];
    if (cmd.out_load) begin
      out_util   <= (req_q == REQ_QUERY) ? sat_v : 12'd0;
      out_margin <= (req_q == REQ_QUERY) ? margin_v : 13'sd0;
      out_boost  <= max_valid ? max_boost : 8'sd0;
      out_active <= max_valid;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.boosted_util = out_util;
  assign rsp.margin       = out_margin;
  assign rsp.peak_boost   = out_boost;
  assign rsp.any_active   = out_active;

endmodule

`default_nettype wire

FILE: hdl/boost_group_util_margin_unit.sv
// Top level of the boost group utilization margin block.
// Joins the bgum_ctrl sequencer and the bgum_dp datapath; uses bgum_pkg and bgum_if.
`default_nettype none

// Boost group utilization margin for one CPU. Each request word (enqueue,
// dequeue, move, query, set boost) yields exactly one response word. Words are
// handled one at a time: the request side is ready only while the sequencer is
// idle. A move of a task to a different group adds a step for the destination
// group. An enqueue that makes a group's count one, and a query whose
// remembered hold has expired, run a rescan that visits one group per cycle
// through a single table read port. Every query then multiplies boost times
// headroom and divides by 100 with a reciprocal multiply. A finished response
// sits in an output register, so the next word is accepted while it waits; a
// later response holds in the sequencer until that register drains.
// Configuration writes go through cfg_we/cfg_index/cfg_data: index 0 is the
// hold timeout in ns, index 1 the CPU capacity (11 bits). Write them only
// while no word is in flight.
module boost_group_util_margin_unit import bgum_pkg::*; #(
  parameter int NUM_GROUPS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  bgum_req_if.sink              req,
  bgum_rsp_if.source            rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t stat;

  // Sequencer: decode the captured word and step through update, rescan, math
  bgum_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  // Datapath: group tables, rescan accumulator, margin arithmetic, output word
  bgum_dp #(
    .NUM_GROUPS (NUM_GROUPS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Never overwrite a response word that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !stat.out_busy)
    else $error("response word loaded while output register busy");

  // A count is either raised or dropped in a cycle, never both
  a_cnt_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(cmd.cnt_inc && cmd.cnt_dec))
    else $error("count increment and decrement in the same cycle");

  // Drop ready right after accepting a word: one word in work at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while a word is in work");

endmodule

`default_nettype wire
